// ----- src/u8d_pkg.sv -----
// u8d_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies; compiled first.
`default_nettype none

package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CntW   = 3;
  localparam int unsigned StatW  = 2;

  localparam logic [CpW-1:0] MaxCodePoint = 21'h10FFFF;

  // Sequence lengths as held in the length register
  localparam logic [CntW-1:0] LenNone = 3'd0;
  localparam logic [CntW-1:0] Len2    = 3'd2;
  localparam logic [CntW-1:0] Len3    = 3'd3;
  localparam logic [CntW-1:0] Len4    = 3'd4;
  localparam logic [CntW-1:0] CntOne  = 3'd1;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_DONE       = 2'd1,
    ST_ERROR      = 2'd2
  } u8d_status_e;

  // Decoder state carried from word to word
  typedef struct packed {
    logic [CntW-1:0] exp_len;
    logic [CntW-1:0] rcv_cnt;
    logic [CpW-1:0]  accum;
  } u8d_state_t;

  localparam u8d_state_t StateClear = '{exp_len: LenNone, rcv_cnt: LenNone, accum: '0};

endpackage : u8d_pkg

`default_nettype wire

// ----- src/u8d_if.sv -----
// u8d_if: valid/ready channel interfaces for the byte input and result output.
// Depends on u8d_pkg.
`default_nettype none

interface u8d_byte_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::ByteW-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface : u8d_byte_if

interface u8d_res_if;
  logic                        valid;
  logic                        ready;
  u8d_pkg::u8d_status_e        status;
  logic [u8d_pkg::CpW-1:0]     code_point;

  modport source (output valid, output status, output code_point, input ready);
  modport sink   (input valid, input status, input code_point, output ready);
endinterface : u8d_res_if

`default_nettype wire

// ----- src/u8d_step.sv -----
// u8d_step: one-byte decode step, current state and byte in, next state and status out.
// Depends on u8d_pkg.
`default_nettype none

module u8d_step (
  input  u8d_pkg::u8d_state_t        state_i,
  input  logic [u8d_pkg::ByteW-1:0]  data_byte_i,
  output u8d_pkg::u8d_state_t        state_o,
  output u8d_pkg::u8d_status_e       status_o
);
  import u8d_pkg::*;

  u8d_state_t      lead_state;
  u8d_status_e     lead_status;
  logic [CpW-1:0]  acc_shift;
  logic [CntW-1:0] cnt_inc;

  // Lead byte classification (also used when a sequence breaks)
  always_comb begin
    lead_state  = StateClear;
    lead_status = ST_ERROR;
    if (!data_byte_i[7]) begin
      lead_state.accum = {{(CpW-ByteW){1'b0}}, data_byte_i};
      lead_status      = ST_DONE;
    end else if (data_byte_i[7:5] == 3'b110) begin
      lead_state  = '{exp_len: Len2, rcv_cnt: CntOne,
                      accum: {{(CpW-5){1'b0}}, data_byte_i[4:0]}};
      lead_status = ST_INCOMPLETE;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_state  = '{exp_len: Len3, rcv_cnt: CntOne,
                      accum: {{(CpW-4){1'b0}}, data_byte_i[3:0]}};
      lead_status = ST_INCOMPLETE;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_state  = '{exp_len: Len4, rcv_cnt: CntOne,
                      accum: {{(CpW-3){1'b0}}, data_byte_i[2:0]}};
      lead_status = ST_INCOMPLETE;
    end
  end

  // Continuation: shift six payload bits in, bump the count
  assign acc_shift = {state_i.accum[CpW-7:0], data_byte_i[5:0]};
  assign cnt_inc   = state_i.rcv_cnt + CntOne;

  always_comb begin
    state_o  = StateClear;
    status_o = ST_ERROR;
    if (state_i.rcv_cnt == LenNone) begin
      state_o  = lead_state;
      status_o = lead_status;
    end else if (state_i.rcv_cnt >= state_i.exp_len) begin
      // inconsistent counters: clear with error
      state_o  = StateClear;
      status_o = ST_ERROR;
    end else if (data_byte_i[7:6] != 2'b10) begin
      // broken sequence: restart on this byte
      state_o  = lead_state;
      status_o = lead_status;
    end else if (cnt_inc != state_i.exp_len) begin
      state_o  = '{exp_len: state_i.exp_len, rcv_cnt: cnt_inc, accum: acc_shift};
      status_o = ST_INCOMPLETE;
    end else if (acc_shift <= MaxCodePoint) begin
      state_o  = '{exp_len: LenNone, rcv_cnt: LenNone, accum: acc_shift};
      status_o = ST_DONE;
    end
  end

endmodule : u8d_step

`default_nettype wire

// ----- src/utf8_stream_decoder_unit.sv -----
// utf8_stream_decoder_unit: top level, input register, decode step, result register.
// Depends on u8d_pkg, u8d_if (u8d_byte_if, u8d_res_if) and u8d_step.
//
//  Channel   Dir  Payload                         Handshake
//  byte_i    in   data_byte[7:0]                  valid/ready
//  res_o     out  status[1:0], code_point[20:0]   valid/ready
//
//  One result word per byte word; sustained rate is one byte per cycle while res_o is ready.
//  Each byte passes the byte register, then is decoded into the result register.
//  Decoder state updates when a byte moves from the byte register into the
//  result register, so back-to-back bytes see each other's effect.
//  Reset (rst_ni low, asynchronous) clears the state and both valid flags.
//  A stall on res_o holds both registers; byte_i stays ready while the byte
//  register is empty or drains in the same cycle.
`default_nettype none

module utf8_stream_decoder_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  u8d_byte_if.sink         byte_i,
  u8d_res_if.source        res_o
);
  import u8d_pkg::*;

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q;
  u8d_status_e      out_stat_q;
  logic [CpW-1:0]   out_cp_q;
  u8d_state_t       state_q, state_d;
  u8d_status_e      step_stat;
  logic             advance;
  logic             in_take;

  // Pipeline flow control
  assign advance      = in_vld_q && (!out_vld_q || res_o.ready);
  assign byte_i.ready = !in_vld_q || advance;
  assign in_take      = byte_i.valid && byte_i.ready;

  // Decode step
  u8d_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .state_o     (state_d),
    .status_o    (step_stat)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_stat_q <= step_stat;
      out_cp_q   <= state_d.accum;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.status     = out_stat_q;
  assign res_o.code_point = out_cp_q;

endmodule : utf8_stream_decoder_unit

`default_nettype wire

// ----- tb/sv/utf8_stream_decoder_unit_test.sv -----
// utf8_stream_decoder_unit_test: self-checking bench for the UTF-8 stream decoder.
// Depends on u8d_pkg, u8d_if and utf8_stream_decoder_unit; drives bytes, predicts
// status/code point per word and checks every result word in order.
module utf8_stream_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int unsigned NumRandomBytes = 750;
  localparam int unsigned CalmTail       = 80;
  localparam int unsigned CycleLimit     = 300000;

  // Pending input word; drain marks a pause until all results are back
  typedef struct {
    logic             drain;
    logic [ByteW-1:0] data;
  } byte_item_t;

  // Expected result word
  typedef struct {
    u8d_status_e      status;
    logic [CpW-1:0]   code_point;
  } cp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  u8d_byte_if byte_if ();
  u8d_res_if  res_if ();

  utf8_stream_decoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .res_o  (res_if)
  );

  always #4 clk_i = ~clk_i;

  byte_item_t  pending_bytes[$];
  cp_word_t    cp_expect[$];
  u8d_state_t  dec_state = StateClear;

  logic        byte_taken;
  logic        drain_wait;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned n_errors;
  int unsigned n_bytes;
  int unsigned n_done;
  int unsigned n_partial;
  int unsigned n_bad;
  int unsigned cycles;

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Handle a byte with no sequence in progress
  function automatic void start_byte(input logic [ByteW-1:0] b, output u8d_status_e st);
    if (b < 8'h80) begin
      dec_state       = StateClear;
      dec_state.accum = CpW'(b);
      st              = ST_DONE;
    end else if ((b & 8'hE0) == 8'hC0) begin
      dec_state = '{exp_len: Len2, rcv_cnt: CntOne, accum: CpW'(b & 8'h1F)};
      st        = ST_INCOMPLETE;
    end else if ((b & 8'hF0) == 8'hE0) begin
      dec_state = '{exp_len: Len3, rcv_cnt: CntOne, accum: CpW'(b & 8'h0F)};
      st        = ST_INCOMPLETE;
    end else if ((b & 8'hF8) == 8'hF0) begin
      dec_state = '{exp_len: Len4, rcv_cnt: CntOne, accum: CpW'(b & 8'h07)};
      st        = ST_INCOMPLETE;
    end else begin
      dec_state = StateClear;
      st        = ST_ERROR;
    end
  endfunction

  // Advance the decoder by one byte and return the resulting word
  function automatic cp_word_t decode_byte(input logic [ByteW-1:0] b);
    cp_word_t    w;
    u8d_status_e st;
    if (dec_state.rcv_cnt == LenNone) begin
      start_byte(b, st);
    end else if (dec_state.rcv_cnt >= dec_state.exp_len) begin
      dec_state = StateClear;
      st        = ST_ERROR;
    end else if (b[7:6] != 2'b10) begin
      // broken sequence: drop it and treat this byte as a fresh start
      dec_state = StateClear;
      start_byte(b, st);
    end else begin
      dec_state.accum   = {dec_state.accum[CpW-7:0], b[5:0]};
      dec_state.rcv_cnt = dec_state.rcv_cnt + CntOne;
      if (dec_state.rcv_cnt != dec_state.exp_len) begin
        st = ST_INCOMPLETE;
      end else if (dec_state.accum <= MaxCodePoint) begin
        dec_state.exp_len = LenNone;
        dec_state.rcv_cnt = LenNone;
        st                = ST_DONE;
      end else begin
        dec_state = StateClear;
        st        = ST_ERROR;
      end
    end
    w.status     = st;
    w.code_point = dec_state.accum;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [ByteW-1:0] b);
    byte_item_t it;
    it.drain = 1'b0;
    it.data  = b;
    pending_bytes.push_back(it);
    n_bytes++;
  endtask

  task automatic push_drain();
    byte_item_t it;
    it.drain = 1'b1;
    it.data  = '0;
    pending_bytes.push_back(it);
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Random lead byte for a 2, 3 or 4 byte sequence; 4-byte leads lean to valid range
  function automatic logic [ByteW-1:0] lead_of(input int unsigned len);
    logic [ByteW-1:0] b;
    case (len)
      2: begin
        b = {3'b110, 5'($urandom_range(0, 31))};
      end
      3: begin
        b = {4'b1110, 4'($urandom_range(0, 15))};
      end
      default: begin
        if ($urandom_range(0, 3) != 0) b = {5'b11110, 3'($urandom_range(0, 4))};
        else b = {5'b11110, 3'($urandom_range(0, 7))};
      end
    endcase
    return b;
  endfunction

  // Lead byte followed by a number of continuation bytes
  task automatic push_seq(input int unsigned len, input int unsigned conts);
    push_byte(lead_of(len));
    repeat (conts) push_byte(cont_byte());
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: new word on the falling edge, held until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    byte_item_t it;
    if (!rst_ni) begin
      byte_if.valid     <= 1'b0;
      byte_if.data_byte <= '0;
      gap_left          <= 0;
      drain_wait        <= 1'b0;
    end else if (byte_if.valid && !byte_taken) begin
      // word still waiting for ready
    end else if (gap_left != 0) begin
      byte_if.valid <= 1'b0;
      gap_left      <= gap_left - 1;
    end else if (drain_wait) begin
      byte_if.valid <= 1'b0;
      if (cp_expect.size() == 0) drain_wait <= 1'b0;
    end else if (pending_bytes.size() == 0) begin
      byte_if.valid <= 1'b0;
    end else if (pending_bytes[0].drain) begin
      it            = pending_bytes.pop_front();
      byte_if.valid <= 1'b0;
      drain_wait    <= 1'b1;
    end else if (pending_bytes.size() > CalmTail && $urandom_range(0, 7) == 0) begin
      byte_if.valid <= 1'b0;
      gap_left      <= $urandom_range(0, 5);
    end else begin
      it                = pending_bytes.pop_front();
      byte_if.valid     <= 1'b1;
      byte_if.data_byte <= it.data;
    end
  end

  // Result sink: ready with random stall bursts, none in the tail
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (pending_bytes.size() > CalmTail && $urandom_range(0, 7) == 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result words, then predict for an accepted byte word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cp_word_t want;
    byte_taken <= byte_if.valid && byte_if.ready;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (cp_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected result word status=%0d cp=0x%06h",
                                    res_if.status, res_if.code_point));
        end else begin
          want = cp_expect.pop_front();
          if (res_if.status !== want.status)
            report_mismatch($sformatf("status got %0d want %s", res_if.status,
                                      want.status.name()));
          if (res_if.code_point !== want.code_point)
            report_mismatch($sformatf("code_point got 0x%06h want 0x%06h",
                                      res_if.code_point, want.code_point));
          case (want.status)
            ST_DONE:       n_done++;
            ST_INCOMPLETE: n_partial++;
            default:       n_bad++;
          endcase
        end
      end
      if (byte_if.valid && byte_if.ready) cp_expect.push_back(decode_byte(byte_if.data_byte));
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, cp_expect.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned rand_bytes;
    bit          paused;
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    res_if.ready      = 1'b0;
    byte_taken        = 1'b0;
    drain_wait        = 1'b0;
    gap_left          = 0;
    stall_left        = 0;
    n_errors          = 0;
    n_bytes           = 0;
    n_done            = 0;
    n_partial         = 0;
    n_bad             = 0;
    cycles            = 0;
    paused            = 1'b0;

    // ASCII extremes, then stray continuation and invalid lead bytes
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h80);
    push_byte(8'hFF);
    push_byte(8'hF8);
    // 3-byte and top legal 4-byte sequences
    push_byte(8'hE2); push_byte(8'h82); push_byte(8'hAC);
    push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
    // value just past the legal range, and the largest 21-bit value
    push_byte(8'hF4); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80);
    push_byte(8'hF7); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
    // sequence broken by ASCII, then by a new lead that completes
    push_byte(8'hE2); push_byte(8'h41);
    push_byte(8'hC3); push_byte(8'hC3); push_byte(8'hA9);
    push_drain();

    // Mostly well-formed sequences with random payload, some broken ones and noise
    rand_bytes = n_bytes;
    while (n_bytes - rand_bytes < NumRandomBytes) begin
      if (!paused && n_bytes - rand_bytes > NumRandomBytes / 2) begin
        push_drain();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 19);
      len  = $urandom_range(2, 4);
      if (kind < 4) begin
        push_byte(8'($urandom_range(0, 127)));
      end else if (kind < 16) begin
        push_seq(2 + (kind - 4) / 4, 1 + (kind - 4) / 4);
      end else if (kind < 18) begin
        push_seq(len, $urandom_range(0, len - 2));
        if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(0, 127)));
        else push_byte(lead_of($urandom_range(2, 4)));
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes.size() != 0 || drain_wait || byte_if.valid) @(posedge clk_i);
    while (cp_expect.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (cp_expect.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", cp_expect.size()));

    $display("Decoded %0d byte words: %0d complete, %0d partial, %0d error results",
             n_bytes, n_done, n_partial, n_bad);
    $display("Covered ASCII, 2/3/4-byte, out-of-range, invalid-lead and broken sequences");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : utf8_stream_decoder_unit_test
